### rtl/hpus_pkg.sv
// Package for the host power-up sequencer: field widths, state, function and
// action codes, register indexes, and the transaction structs shared by the modules.
// No dependencies.
package hpus_pkg;

  // State codes
  localparam logic [3:0] ST_INIT       = 4'd0;
  localparam logic [3:0] ST_RELEASE    = 4'd1;
  localparam logic [3:0] ST_DEBOUNCE   = 4'd2;
  localparam logic [3:0] ST_MAIN       = 4'd3;
  localparam logic [3:0] ST_DISCHARGE  = 4'd4;
  localparam logic [3:0] ST_POWERED    = 4'd5;
  localparam logic [3:0] ST_CORE_RESET = 4'd6;
  localparam logic [3:0] ST_WAIT_VSYS  = 4'd7;
  localparam logic [3:0] ST_WAIT_EXT   = 4'd8;

  // Input functions
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_ENABLE = 2'd1;
  localparam logic [1:0] FN_EXT    = 2'd2;
  localparam logic [1:0] FN_FORCE  = 2'd3;

  // Action codes
  localparam logic [3:0] ACT_NONE         = 4'd0;
  localparam logic [3:0] ACT_START        = 4'd1;
  localparam logic [3:0] ACT_RELEASE_PINS = 4'd2;
  localparam logic [3:0] ACT_ARM_ENABLE   = 4'd3;
  localparam logic [3:0] ACT_POWER_UP     = 4'd4;
  localparam logic [3:0] ACT_FAIL         = 4'd5;
  localparam logic [3:0] ACT_DISCHARGE    = 4'd6;
  localparam logic [3:0] ACT_POWERED      = 4'd7;
  localparam logic [3:0] ACT_CORE_RESET   = 4'd8;
  localparam logic [3:0] ACT_POLL_WAIT    = 4'd9;
  localparam logic [3:0] ACT_EXT_WAIT     = 4'd10;
  localparam logic [3:0] ACT_HOST_RESET   = 4'd11;
  localparam logic [3:0] ACT_VSYS_OK      = 4'd12;

  // Configuration register indexes
  localparam logic [2:0] REG_RELEASE_DELAY = 3'd0;
  localparam logic [2:0] REG_ENABLE_WAIT   = 3'd1;
  localparam logic [2:0] REG_RETRY_DELAY   = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd3;
  localparam logic [2:0] REG_VSYS_THRESH   = 3'd4;
  localparam logic [2:0] REG_POLL_LIMIT    = 3'd5;
  localparam logic [2:0] REG_POLL_PERIOD   = 3'd6;

  // Configuration reset values
  localparam logic [15:0] RST_RELEASE_DELAY = 16'd312;
  localparam logic [15:0] RST_ENABLE_WAIT   = 16'd328;
  localparam logic [15:0] RST_RETRY_DELAY   = 16'd1312;
  localparam logic [15:0] RST_DEBOUNCE      = 16'd16;
  localparam logic [11:0] RST_VSYS_THRESH   = 12'h777;
  localparam logic [9:0]  RST_POLL_LIMIT    = 10'd1000;
  localparam logic [7:0]  RST_POLL_PERIOD   = 8'd33;

  typedef struct packed {
    logic [15:0] reset_release_delay;
    logic [15:0] enable_wait_ticks;
    logic [15:0] retry_delay;
    logic [15:0] debounce_ticks;
    logic [11:0] vsys_threshold;
    logic [9:0]  vsys_poll_limit;
    logic [7:0]  vsys_poll_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        enable_level;
    logic        vsys_low_flag;
    logic [11:0] vsys_sample;
    logic        ext_power_present;
    logic        want_core_reset;
    logic        want_ext_wait;
    logic [3:0]  forced_state;
  } item_t;

  typedef struct packed {
    logic [3:0] state_now;
    logic [3:0] action;
    logic       timer_active;
  } result_t;

endpackage

### rtl/hpus_cfg.sv
// Configuration register file of the host power-up sequencer.
// Depends on hpus_pkg for register indexes, reset values and cfg_t.
module hpus_cfg
  import hpus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Always ready: every write is taken in the cycle it is presented
  assign cfg_ready = 1'b1;

  // Hold registers, write the addressed one; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_release_delay <= RST_RELEASE_DELAY;
      cfg.enable_wait_ticks   <= RST_ENABLE_WAIT;
      cfg.retry_delay         <= RST_RETRY_DELAY;
      cfg.debounce_ticks      <= RST_DEBOUNCE;
      cfg.vsys_threshold      <= RST_VSYS_THRESH;
      cfg.vsys_poll_limit     <= RST_POLL_LIMIT;
      cfg.vsys_poll_period    <= RST_POLL_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RELEASE_DELAY: cfg.reset_release_delay <= cfg_data;
        REG_ENABLE_WAIT:   cfg.enable_wait_ticks   <= cfg_data;
        REG_RETRY_DELAY:   cfg.retry_delay         <= cfg_data;
        REG_DEBOUNCE:      cfg.debounce_ticks      <= cfg_data;
        REG_VSYS_THRESH:   cfg.vsys_threshold      <= cfg_data[11:0];
        REG_POLL_LIMIT:    cfg.vsys_poll_limit     <= cfg_data[9:0];
        REG_POLL_PERIOD:   cfg.vsys_poll_period    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/hpus_seq.sv
// Sequencer state and next-state logic: state code, delay timer, pending run
// flag and supply poll count. Depends on hpus_pkg.
module hpus_seq
  import hpus_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [3:0]             seq_state, seq_state_next;
  logic [TIMER_WIDTH-1:0] delay_count, delay_count_next;
  logic                   delay_running, delay_running_next;
  logic                   run_pending, run_pending_next;
  logic [9:0]             poll_count, poll_count_next;

  logic                   do_run;
  logic                   go_main;
  logic                   go_ext;
  logic                   load;
  logic [15:0]            load_ticks;
  logic [TIMER_WIDTH+15:0] load_wide;
  logic [9:0]             poll_inc;
  logic [3:0]             action;

  // Timer load value masked (or zero extended) to the timer width
  assign load_wide = {{TIMER_WIDTH{1'b0}}, load_ticks};
  assign poll_inc  = poll_count + 10'd1;

  // Work out the next state for one transaction
  always_comb begin
    seq_state_next     = seq_state;
    delay_count_next   = delay_count;
    delay_running_next = delay_running;
    run_pending_next   = run_pending;
    poll_count_next    = poll_count;
    action             = ACT_NONE;
    do_run             = 1'b0;
    go_main            = 1'b0;
    go_ext             = 1'b0;
    load               = 1'b0;
    load_ticks         = cfg.retry_delay;

    case (item.func)
      FN_TICK: begin
        if (run_pending) begin
          run_pending_next = 1'b0;
          do_run           = 1'b1;
        end else if (delay_running) begin
          if (delay_count <= TIMER_WIDTH'(1)) begin
            delay_count_next   = '0;
            delay_running_next = 1'b0;
            do_run             = 1'b1;
          end else begin
            delay_count_next = delay_count - TIMER_WIDTH'(1);
          end
        end
      end
      FN_ENABLE: begin
        if (seq_state == ST_MAIN) begin
          run_pending_next = 1'b1;
        end else begin
          action = ACT_HOST_RESET;
        end
      end
      FN_EXT: begin
        if (seq_state == ST_WAIT_EXT) begin
          seq_state_next   = ST_WAIT_VSYS;
          run_pending_next = 1'b1;
          poll_count_next  = '0;
        end
      end
      default: begin
        seq_state_next  = item.forced_state;
        poll_count_next = '0;
      end
    endcase

    // State handler
    if (do_run) begin
      case (seq_state)
        ST_INIT: begin
          seq_state_next = ST_RELEASE;
          load           = 1'b1;
          load_ticks     = cfg.reset_release_delay;
          action         = ACT_START;
        end
        ST_RELEASE: begin
          seq_state_next = ST_DEBOUNCE;
          load           = 1'b1;
          load_ticks     = cfg.debounce_ticks;
          action         = ACT_RELEASE_PINS;
        end
        ST_DEBOUNCE: begin
          seq_state_next = ST_MAIN;
          if (!item.enable_level) begin
            load       = 1'b1;
            load_ticks = cfg.enable_wait_ticks;
            action     = ACT_ARM_ENABLE;
          end else begin
            go_main = 1'b1;
          end
        end
        ST_MAIN: go_main = 1'b1;
        ST_DISCHARGE: begin
          if (item.want_core_reset) begin
            seq_state_next = ST_CORE_RESET;
          end else if (item.want_ext_wait) begin
            seq_state_next = ST_WAIT_EXT;
          end else begin
            seq_state_next = ST_INIT;
          end
          load   = 1'b1;
          action = ACT_DISCHARGE;
        end
        ST_POWERED:    action = ACT_POWERED;
        ST_CORE_RESET: action = ACT_CORE_RESET;
        ST_WAIT_VSYS: begin
          if (!item.vsys_low_flag && item.vsys_sample > cfg.vsys_threshold) begin
            seq_state_next   = ST_INIT;
            run_pending_next = 1'b1;
            poll_count_next  = '0;
            action           = ACT_VSYS_OK;
          end else if (poll_inc >= cfg.vsys_poll_limit
                       || cfg.vsys_poll_limit <= 10'd1) begin
            poll_count_next = '0;
            seq_state_next  = ST_WAIT_EXT;
            go_ext          = 1'b1;
          end else begin
            poll_count_next = poll_inc;
            load            = 1'b1;
            load_ticks      = {8'd0, cfg.vsys_poll_period};
            action          = ACT_POLL_WAIT;
          end
        end
        ST_WAIT_EXT: go_ext = 1'b1;
        default: ;
      endcase
    end

    // Main handler: power up on enable, otherwise fail and schedule a retry
    if (go_main) begin
      if (item.enable_level) begin
        delay_running_next = 1'b0;
        delay_count_next   = '0;
        action             = ACT_POWER_UP;
      end else begin
        seq_state_next = ST_INIT;
        load           = 1'b1;
        action         = ACT_FAIL;
      end
    end

    // Wait for external power
    if (go_ext) begin
      if (item.ext_power_present) begin
        seq_state_next   = ST_WAIT_VSYS;
        run_pending_next = 1'b1;
        action           = ACT_POLL_WAIT;
      end else begin
        action = ACT_EXT_WAIT;
      end
    end

    // Start the timer
    if (load) begin
      delay_count_next   = load_wide[TIMER_WIDTH-1:0];
      delay_running_next = 1'b1;
    end
  end

  assign result.state_now    = seq_state_next;
  assign result.action       = action;
  assign result.timer_active = delay_running_next;

  // Advance sequencer state once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state     <= ST_WAIT_VSYS;
      delay_count   <= '0;
      delay_running <= 1'b0;
      run_pending   <= 1'b1;
      poll_count    <= '0;
    end else if (fire) begin
      seq_state     <= seq_state_next;
      delay_count   <= delay_count_next;
      delay_running <= delay_running_next;
      run_pending   <= run_pending_next;
      poll_count    <= poll_count_next;
    end
  end

  // A stopped timer always reads zero
  a_timer_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !delay_running |-> delay_count == '0)
    else $error("timer stopped with nonzero count");

  // State moves only on a transaction
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(seq_state) && $stable(run_pending) && $stable(poll_count))
    else $error("sequencer state changed without a transaction");

  // A forced state lands as given and clears the poll count
  a_force: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == FN_FORCE |=>
      seq_state == $past(item.forced_state) && poll_count == '0)
    else $error("forced state not applied");

endmodule

### rtl/host_power_up_sequencer_unit.sv
// Top level of the host power-up sequencer: input register, sequencer core,
// result register and configuration port. Depends on hpus_pkg, hpus_cfg, hpus_seq.

// The sequencer takes one transaction per clock while item_stall is low and returns
// exactly one result for each. The item is captured in an input register, the next
// state and action are formed in one pass of logic in the sequencer core, and the
// result is held in an output register. Stall on the result side propagates back
// to item_stall only when both registers are full, so a full rate of one item per
// cycle holds whenever results are taken.
// Configuration writes complete in the cycle they are presented (cfg_ready is
// always high) and must be issued only while no transaction is in flight.
// TIMER_WIDTH sets the width of the delay counter; timer loads are masked to it.
module host_power_up_sequencer_unit
  import hpus_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  func,
  input  logic        enable_level,
  input  logic        vsys_low_flag,
  input  logic [11:0] vsys_sample,
  input  logic        ext_power_present,
  input  logic        want_core_reset,
  input  logic        want_ext_wait,
  input  logic [3:0]  forced_state,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  state_now,
  output logic [3:0]  action,
  output logic        timer_active,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   hold_item;
  logic    hold_valid;
  result_t core_result;
  result_t result;
  logic    advance;
  logic    fire;
  logic    accept;

  hpus_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpus_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (hold_item),
    .result (core_result)
  );

  // Handshake: the result register frees up when empty or taken
  assign advance    = !result_valid || !result_stall;
  assign fire       = hold_valid && advance;
  assign item_stall = hold_valid && !advance;
  assign accept     = item_valid && !item_stall;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item.func              <= func;
      hold_item.enable_level      <= enable_level;
      hold_item.vsys_low_flag     <= vsys_low_flag;
      hold_item.vsys_sample       <= vsys_sample;
      hold_item.ext_power_present <= ext_power_present;
      hold_item.want_core_reset   <= want_core_reset;
      hold_item.want_ext_wait     <= want_ext_wait;
      hold_item.forced_state      <= forced_state;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

  assign state_now    = result.state_now;
  assign action       = result.action;
  assign timer_active = result.timer_active;

  // A stalled input register always holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> hold_valid && result_valid)
    else $error("item stalled with free input register");

  // A held result is not dropped while stalled
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result lost or changed");

endmodule

### tb/host_power_up_sequencer_checker.sv
// Checker for the host power-up sequencer: watches the item, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on hpus_pkg.
module host_power_up_sequencer_checker
  import hpus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [1:0]  func,
  input  logic        enable_level,
  input  logic        vsys_low_flag,
  input  logic [11:0] vsys_sample,
  input  logic        ext_power_present,
  input  logic        want_core_reset,
  input  logic        want_ext_wait,
  input  logic [3:0]  forced_state,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [3:0]  state_now,
  input  logic [3:0]  action,
  input  logic        timer_active,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          in_flight,
  output logic [15:0] actions_seen
);

  // Shadow registers and sequencer state
  cfg_t        regs;
  logic [3:0]  seq_st;
  logic [15:0] dly_cnt;
  logic        dly_on;
  logic        run_queued;
  logic [9:0]  polls;
  result_t     pending_results[$];

  function automatic void arm_delay(logic [15:0] ticks);
    dly_cnt = ticks;
    dly_on  = 1'b1;
  endfunction

  function automatic logic [3:0] ext_wait_step(item_t it);
    if (it.ext_power_present) begin
      seq_st     = ST_WAIT_VSYS;
      run_queued = 1'b1;
      return ACT_POLL_WAIT;
    end
    return ACT_EXT_WAIT;
  endfunction

  // Stop the timer, then either power up or fall back to init with a retry
  function automatic logic [3:0] main_step(item_t it);
    dly_on  = 1'b0;
    dly_cnt = '0;
    if (it.enable_level) return ACT_POWER_UP;
    seq_st = ST_INIT;
    arm_delay(regs.retry_delay);
    return ACT_FAIL;
  endfunction

  function automatic logic [3:0] handler_step(item_t it);
    case (seq_st)
      ST_INIT: begin
        seq_st = ST_RELEASE;
        arm_delay(regs.reset_release_delay);
        return ACT_START;
      end
      ST_RELEASE: begin
        seq_st = ST_DEBOUNCE;
        arm_delay(regs.debounce_ticks);
        return ACT_RELEASE_PINS;
      end
      ST_DEBOUNCE: begin
        seq_st = ST_MAIN;
        if (!it.enable_level) begin
          arm_delay(regs.enable_wait_ticks);
          return ACT_ARM_ENABLE;
        end
        return main_step(it);
      end
      ST_MAIN: return main_step(it);
      ST_DISCHARGE: begin
        if (it.want_core_reset) seq_st = ST_CORE_RESET;
        else if (it.want_ext_wait) seq_st = ST_WAIT_EXT;
        else seq_st = ST_INIT;
        arm_delay(regs.retry_delay);
        return ACT_DISCHARGE;
      end
      ST_POWERED: return ACT_POWERED;
      ST_CORE_RESET: return ACT_CORE_RESET;
      // One supply poll per handler run
      ST_WAIT_VSYS: begin
        if (!it.vsys_low_flag && it.vsys_sample > regs.vsys_threshold) begin
          seq_st     = ST_INIT;
          run_queued = 1'b1;
          polls      = '0;
          return ACT_VSYS_OK;
        end
        polls = polls + 10'd1;
        if (polls >= regs.vsys_poll_limit || regs.vsys_poll_limit <= 10'd1) begin
          polls  = '0;
          seq_st = ST_WAIT_EXT;
          return ext_wait_step(it);
        end
        arm_delay({8'd0, regs.vsys_poll_period});
        return ACT_POLL_WAIT;
      end
      ST_WAIT_EXT: return ext_wait_step(it);
      default: return ACT_NONE;
    endcase
  endfunction

  function automatic result_t next_sequencer_result(item_t it);
    logic [3:0] act;
    act = ACT_NONE;
    case (it.func)
      FN_TICK: begin
        if (run_queued) begin
          run_queued = 1'b0;
          act = handler_step(it);
        end else if (dly_on) begin
          if (dly_cnt <= 16'd1) begin
            dly_cnt = '0;
            dly_on  = 1'b0;
            act = handler_step(it);
          end else begin
            dly_cnt = dly_cnt - 16'd1;
          end
        end
      end
      FN_ENABLE: begin
        if (seq_st == ST_MAIN) run_queued = 1'b1;
        else act = ACT_HOST_RESET;
      end
      FN_EXT: begin
        if (seq_st == ST_WAIT_EXT) begin
          seq_st     = ST_WAIT_VSYS;
          run_queued = 1'b1;
          polls      = '0;
        end
      end
      default: begin
        seq_st = it.forced_state;
        polls  = '0;
      end
    endcase
    return '{state_now: seq_st, action: act, timer_active: dly_on};
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Track configuration, predict on item transactions, compare on result ones
  always @(posedge clk) begin
    result_t want;
    item_t   it;
    if (rst) begin
      regs.reset_release_delay = RST_RELEASE_DELAY;
      regs.enable_wait_ticks   = RST_ENABLE_WAIT;
      regs.retry_delay         = RST_RETRY_DELAY;
      regs.debounce_ticks      = RST_DEBOUNCE;
      regs.vsys_threshold      = RST_VSYS_THRESH;
      regs.vsys_poll_limit     = RST_POLL_LIMIT;
      regs.vsys_poll_period    = RST_POLL_PERIOD;
      seq_st       = ST_WAIT_VSYS;
      dly_cnt      = '0;
      dly_on       = 1'b0;
      run_queued   = 1'b1;
      polls        = '0;
      actions_seen = '0;
      pending_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        actions_seen[action] = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding: state_now %0d action %0d",
                 state_now, action);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("state_now", want.state_now, state_now);
          check_field("action", want.action, action);
          check_field("timer_active", want.timer_active, timer_active);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RELEASE_DELAY: regs.reset_release_delay = cfg_data;
          REG_ENABLE_WAIT:   regs.enable_wait_ticks   = cfg_data;
          REG_RETRY_DELAY:   regs.retry_delay         = cfg_data;
          REG_DEBOUNCE:      regs.debounce_ticks      = cfg_data;
          REG_VSYS_THRESH:   regs.vsys_threshold      = cfg_data[11:0];
          REG_POLL_LIMIT:    regs.vsys_poll_limit     = cfg_data[9:0];
          REG_POLL_PERIOD:   regs.vsys_poll_period    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        it = {func, enable_level, vsys_low_flag, vsys_sample, ext_power_present,
              want_core_reset, want_ext_wait, forced_state};
        pending_results.push_back(next_sequencer_result(it));
      end
    end
    in_flight = pending_results.size();
  end

endmodule

### tb/host_power_up_sequencer_unit_tb.sv
// Testbench top for host_power_up_sequencer_unit: clock, reset, item and
// register stimulus, result-side stalls and the verdict.
// Depends on hpus_pkg, the sequencer RTL and host_power_up_sequencer_checker.
module host_power_up_sequencer_unit_tb;
  import hpus_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  func;
  logic        enable_level;
  logic        vsys_low_flag;
  logic [11:0] vsys_sample;
  logic        ext_power_present;
  logic        want_core_reset;
  logic        want_ext_wait;
  logic [3:0]  forced_state;
  logic        result_valid;
  logic        result_stall;
  logic [3:0]  state_now;
  logic [3:0]  action;
  logic        timer_active;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          mismatches;
  int          in_flight;
  logic [15:0] actions_seen;

  // Run controls shared with the result side
  logic        calm = 1'b0;
  logic        press_on = 1'b0;
  logic        idle_on = 1'b1;
  logic        host_level = 1'b0;
  int          items_sent = 0;
  int          settings_used = 1;

  always #5 clk = ~clk;

  host_power_up_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .enable_level(enable_level), .vsys_low_flag(vsys_low_flag),
    .vsys_sample(vsys_sample), .ext_power_present(ext_power_present),
    .want_core_reset(want_core_reset), .want_ext_wait(want_ext_wait),
    .forced_state(forced_state),
    .result_valid(result_valid), .result_stall(result_stall),
    .state_now(state_now), .action(action), .timer_active(timer_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  host_power_up_sequencer_checker u_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .enable_level(enable_level), .vsys_low_flag(vsys_low_flag),
    .vsys_sample(vsys_sample), .ext_power_present(ext_power_present),
    .want_core_reset(want_core_reset), .want_ext_wait(want_ext_wait),
    .forced_state(forced_state),
    .result_valid(result_valid), .result_stall(result_stall),
    .state_now(state_now), .action(action), .timer_active(timer_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .in_flight(in_flight), .actions_seen(actions_seen)
  );

  function automatic item_t mk(logic [1:0] f, logic lvl, logic low, logic [11:0] smp,
                               logic ext, logic core, logic extw, logic [3:0] fst);
    return {f, lvl, low, smp, ext, core, extw, fst};
  endfunction

  // Mostly ticks with random content; edges, power events and forced states as noise
  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 5) == 0) host_level = ~host_level;
    it.func = (pick < 72) ? FN_TICK : (pick < 81) ? FN_ENABLE :
              (pick < 91) ? FN_EXT : FN_FORCE;
    it.enable_level      = host_level;
    it.vsys_low_flag     = ($urandom_range(0, 3) == 0);
    it.vsys_sample       = 12'($urandom_range(0, 4095));
    it.ext_power_present = 1'($urandom_range(0, 1));
    it.want_core_reset   = ($urandom_range(0, 2) == 0);
    it.want_ext_wait     = 1'($urandom_range(0, 1));
    it.forced_state      = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8));
    return it;
  endfunction

  // Offer one item, with an optional idle burst ahead of it; return on acceptance
  task automatic send_item(item_t it);
    int gap;
    gap = (idle_on && !calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid        <= 1'b1;
    func              <= it.func;
    enable_level      <= it.enable_level;
    vsys_low_flag     <= it.vsys_low_flag;
    vsys_sample       <= it.vsys_sample;
    ext_power_present <= it.ext_power_present;
    want_core_reset   <= it.want_core_reset;
    want_ext_wait     <= it.want_ext_wait;
    forced_state      <= it.forced_state;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result plus the pipeline depth
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] rel, logic [15:0] ena, logic [15:0] rty,
                           logic [15:0] deb, logic [11:0] thr, logic [9:0] lim,
                           logic [7:0] per);
    write_reg(REG_RELEASE_DELAY, rel);
    write_reg(REG_ENABLE_WAIT, ena);
    write_reg(REG_RETRY_DELAY, rty);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_VSYS_THRESH, {4'd0, thr});
    write_reg(REG_POLL_LIMIT, {6'd0, lim});
    write_reg(REG_POLL_PERIOD, {8'd0, per});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: short stall bursts between free runs, one long hold-off under pressure
  initial begin : result_taker
    int span;
    bit held_long;
    bit was_stalled;
    result_stall = 1'b0;
    held_long    = 1'b0;
    was_stalled  = 1'b0;
    forever begin
      @(negedge clk);
      if (press_on && !held_long) begin
        held_long = 1'b1;
        span = 60;
        result_stall <= 1'b1;
        was_stalled = 1'b1;
      end else if (!calm && !was_stalled && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 4);
        result_stall <= 1'b1;
        was_stalled = 1'b1;
      end else begin
        span = $urandom_range(1, 16);
        result_stall <= 1'b0;
        was_stalled = 1'b0;
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int n_items;
    rst               = 1'b1;
    item_valid        = 1'b0;
    func              = FN_TICK;
    enable_level      = 1'b0;
    vsys_low_flag     = 1'b0;
    vsys_sample       = '0;
    ext_power_present = 1'b0;
    want_core_reset   = 1'b0;
    want_ext_wait     = 1'b0;
    forced_state      = ST_INIT;
    cfg_valid         = 1'b0;
    cfg_index         = REG_RELEASE_DELAY;
    cfg_data          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: supply just above the default threshold, stray edge and power event
    send_item(mk(FN_TICK, 0, 0, 12'h778, 0, 0, 0, ST_INIT));
    send_item(mk(FN_ENABLE, 1, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_EXT, 0, 0, 12'h000, 1, 0, 0, ST_INIT));
    drain();

    // Shortest delays so every tick runs the handler
    write_all(16'd1, 16'd1, 16'd1, 16'd1, 12'h800, 10'd2, 8'd1);
    // Walk init, release, debounce with enable low, then main with enable high
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 1, 0, 12'h000, 0, 0, 0, ST_INIT));
    // Enable edge in main, low level: fail shutdown and retry
    send_item(mk(FN_ENABLE, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    // Discharge into core reset, then the core reset handler
    send_item(mk(FN_FORCE, 0, 0, 12'h000, 0, 0, 0, ST_DISCHARGE));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 1, 1, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    // Discharge into wait for external power, with no power present
    send_item(mk(FN_FORCE, 0, 0, 12'h000, 0, 0, 0, ST_MAIN));
    send_item(mk(FN_ENABLE, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_FORCE, 0, 0, 12'h000, 0, 0, 0, ST_DISCHARGE));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 1, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h000, 0, 0, 0, ST_INIT));
    // Power event in wait ext; sample equal to threshold; poll limit with power present
    send_item(mk(FN_EXT, 0, 0, 12'h000, 1, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h800, 0, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 1, 12'hfff, 1, 0, 0, ST_INIT));
    send_item(mk(FN_TICK, 0, 0, 12'h801, 0, 0, 0, ST_INIT));
    // Powered handler, then a state code with no handler
    send_item(mk(FN_FORCE, 1, 1, 12'hfff, 1, 1, 1, ST_POWERED));
    send_item(mk(FN_TICK, 1, 1, 12'hfff, 1, 1, 1, ST_INIT));
    send_item(mk(FN_FORCE, 0, 0, 12'h000, 0, 0, 0, 4'd15));
    send_item(mk(FN_ENABLE, 1, 0, 12'h000, 0, 0, 0, ST_INIT));
    send_item(mk(FN_FORCE, 0, 0, 12'h000, 0, 0, 0, ST_WAIT_VSYS));
    drain();

    // Random phases: minimum settings, maximum settings, then short random delays
    for (int p = 0; p < 10; p++) begin
      if (p == 0)
        write_all(16'd1, 16'd1, 16'd1, 16'd1, 12'd0, 10'd1, 8'd1);
      else if (p == 1)
        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 10'd1023, 8'd255);
      else
        write_all(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                  12'($urandom_range(0, 4095)), 10'($urandom_range(1, 6)),
                  8'($urandom_range(1, 4)));
      n_items = (p == 1) ? 80 : 150;
      press_on <= (p == 4);
      calm     <= (p == 9);
      idle_on  <= (p != 4) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n_items; i++) send_item(random_item());
      drain();
    end

    repeat (8) @(negedge clk);
    $display("summary: %0d item transactions checked over %0d register settings",
             items_sent, settings_used);
    $display("summary: action codes returned (bit mask) %h", actions_seen);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
